// File: hw/rtl/mprf_pkg.sv
package mprf_pkg;

  localparam int NEIGHBOUR_SLOTS  = 8;
  localparam int RECENT_DEPTH     = 8;
  localparam int MAX_PACKET_BYTES = 255;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QUEUE_PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [7:0]  CNT_MAX    = 8'(MAX_PACKET_BYTES);
  localparam logic [7:0]  RUNT_LIMIT = 8'd6;
  localparam logic [7:0]  HDR_BYTES  = 8'd4;
  localparam logic [7:0]  CRC_SKIP   = 8'd2;

  localparam logic [2:0] CFG_OWN_ADDRESS   = 3'd0;
  localparam logic [2:0] CFG_HELLO_CODE    = 3'd1;
  localparam logic [2:0] CFG_NLIST_CODE    = 3'd2;
  localparam logic [2:0] CFG_MESSAGE_CODE  = 3'd3;
  localparam logic [2:0] CFG_SINGLE_HOP    = 3'd4;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_HELLO   = 3'd1,
    KIND_NLIST   = 3'd2,
    KIND_FOR_ME  = 3'd3,
    KIND_FORWARD = 3'd4,
    KIND_DROP    = 3'd5,
    KIND_RUNT    = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    NBR_NONE    = 2'd0,
    NBR_STORED  = 2'd1,
    NBR_PRESENT = 2'd2,
    NBR_FULL    = 2'd3
  } nbr_outcome_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] hello_code;
    logic [7:0] nlist_code;
    logic [7:0] message_code;
    logic [7:0] single_hop_code;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic        crc_match;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] rx_crc;
  } desc_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/mesh_packet_receive_filter_core.sv
// Mesh packet receive filter.
// in_*: one packet byte per item, in_last_byte marks the final byte. Bytes are
//   taken one per cycle while a two-entry descriptor queue has room.
// out_*: one result item per packet, with its kind, CRC-16/XModem match,
//   header addresses, neighbour table outcome and forward decision.
// cfg_*: register writes (index 0..4, others ignored), always ready; write
//   only while no packet is in flight.
// The result waits in the queue after the edge that takes the last byte, then
//   loads the back-end output register once that register is free or being read.
// Throughput: one byte per cycle while the queue has room; the back end resolves one
//   packet per cycle while its output is free, by combinational table lookup and update.
// A stalled receiver holds the result in the output register; up to two more
//   packets wait in the queue before in_ready drops.
// Reset (rst_n low, synchronous) clears the packet state, the neighbour table,
//   the recent checksum store and the queue, and loads the register defaults.
module mesh_packet_receive_filter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_packet_kind,
  output logic       out_crc_match,
  output logic [7:0] out_source_address,
  output logic [7:0] out_dest_address,
  output logic       out_reply_hello,
  output logic [1:0] out_neighbour_outcome,
  output logic [2:0] out_neighbour_slot,
  output logic       out_seen_before,
  output logic       out_forward_now,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  mprf_pkg::cfg_t  cfg_r;
  mprf_pkg::desc_t push_desc, pop_desc;
  logic            push, q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address     <= 8'd65;
      cfg_r.hello_code      <= 8'd72;
      cfg_r.nlist_code      <= 8'd78;
      cfg_r.message_code    <= 8'd77;
      cfg_r.single_hop_code <= 8'd83;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mprf_pkg::CFG_OWN_ADDRESS:  cfg_r.own_address     <= cfg_data;
        mprf_pkg::CFG_HELLO_CODE:   cfg_r.hello_code      <= cfg_data;
        mprf_pkg::CFG_NLIST_CODE:   cfg_r.nlist_code      <= cfg_data;
        mprf_pkg::CFG_MESSAGE_CODE: cfg_r.message_code    <= cfg_data;
        mprf_pkg::CFG_SINGLE_HOP:   cfg_r.single_hop_code <= cfg_data;
        default: ;
      endcase
    end
  end

  mprf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .cfg          (cfg_r),
    .q_full       (q_full),
    .push         (push),
    .push_desc    (push_desc)
  );

  mprf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_desc  (pop_desc)
  );

  mprf_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_desc                (pop_desc),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_packet_kind       (out_packet_kind),
    .out_crc_match         (out_crc_match),
    .out_source_address    (out_source_address),
    .out_dest_address      (out_dest_address),
    .out_reply_hello       (out_reply_hello),
    .out_neighbour_outcome (out_neighbour_outcome),
    .out_neighbour_slot    (out_neighbour_slot),
    .out_seen_before       (out_seen_before),
    .out_forward_now       (out_forward_now)
  );

endmodule

// File: hw/rtl/mprf_front.sv
module mprf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  input  mprf_pkg::cfg_t      cfg,
  input  logic                q_full,
  output logic                push,
  output mprf_pkg::desc_t     push_desc
);

  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      tail0_r, tail0_nxt;
  logic [7:0]      tail1_r, tail1_nxt;
  logic [3:0][7:0] hdr_r, hdr_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic            accept;
  mprf_pkg::kind_t kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && in_last_byte;

  always_comb begin
    crc_nxt   = (cnt_r >= mprf_pkg::CRC_SKIP) ? mprf_pkg::crc_feed(crc_r, tail0_r) : crc_r;
    tail0_nxt = tail1_r;
    tail1_nxt = in_data_byte;
    hdr_nxt   = hdr_r;
    if (cnt_r < mprf_pkg::HDR_BYTES) begin
      hdr_nxt[cnt_r[1:0]] = in_data_byte;
    end
    cnt_nxt = (cnt_r < mprf_pkg::CNT_MAX) ? cnt_r + 8'd1 : cnt_r;
  end

  // classify on the final byte
  always_comb begin
    kind = mprf_pkg::KIND_UNKNOWN;
    if (cnt_nxt < mprf_pkg::RUNT_LIMIT) begin
      kind = mprf_pkg::KIND_RUNT;
    end else if (hdr_nxt[0] == cfg.hello_code) begin
      kind = mprf_pkg::KIND_HELLO;
    end else if (hdr_nxt[0] == cfg.nlist_code) begin
      kind = mprf_pkg::KIND_NLIST;
    end else if (hdr_nxt[0] == cfg.message_code) begin
      if (hdr_nxt[3] == cfg.own_address) begin
        kind = mprf_pkg::KIND_FOR_ME;
      end else if (hdr_nxt[1] != cfg.single_hop_code) begin
        kind = mprf_pkg::KIND_FORWARD;
      end else begin
        kind = mprf_pkg::KIND_DROP;
      end
    end
    push_desc.kind      = kind;
    push_desc.rx_crc    = {tail0_nxt, tail1_nxt};
    push_desc.crc_match = (kind != mprf_pkg::KIND_RUNT) && ({tail0_nxt, tail1_nxt} == crc_nxt);
    push_desc.src       = hdr_nxt[2];
    push_desc.dst       = hdr_nxt[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      tail0_r <= '0;
      tail1_r <= '0;
      hdr_r   <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      if (in_last_byte) begin
        crc_r   <= '0;
        tail0_r <= '0;
        tail1_r <= '0;
        hdr_r   <= '0;
        cnt_r   <= '0;
      end else begin
        crc_r   <= crc_nxt;
        tail0_r <= tail0_nxt;
        tail1_r <= tail1_nxt;
        hdr_r   <= hdr_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/mprf_queue.sv
module mprf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mprf_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output mprf_pkg::desc_t pop_desc
);

  mprf_pkg::desc_t                    mem_r [mprf_pkg::QUEUE_DEPTH];
  logic [mprf_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [mprf_pkg::QUEUE_CNT_W-1:0]   cnt_r;
  logic                               do_push, do_pop;

  assign full      = (cnt_r == mprf_pkg::QUEUE_CNT_W'(mprf_pkg::QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_desc  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == mprf_pkg::QUEUE_PTR_W'(mprf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == mprf_pkg::QUEUE_PTR_W'(mprf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/mprf_back.sv
module mprf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  mprf_pkg::desc_t q_desc,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_packet_kind,
  output logic            out_crc_match,
  output logic [7:0]      out_source_address,
  output logic [7:0]      out_dest_address,
  output logic            out_reply_hello,
  output logic [1:0]      out_neighbour_outcome,
  output logic [2:0]      out_neighbour_slot,
  output logic            out_seen_before,
  output logic            out_forward_now
);

  logic [mprf_pkg::NEIGHBOUR_SLOTS-1:0][7:0] nbr_r, nbr_nxt;
  logic [mprf_pkg::RECENT_DEPTH-1:0][15:0]   rc_r, rc_nxt;

  logic                   out_valid_r;
  mprf_pkg::kind_t        kind_r;
  logic                   match_r, reply_r, seen_r, fwd_r;
  logic [7:0]             src_r, dst_r;
  mprf_pkg::nbr_outcome_t outcome_r, outcome;
  logic [2:0]             slot_r, slot, empty_slot;

  logic is_hello, is_fwd, present, found, seen;

  assign q_pop    = q_valid && (!out_valid_r || out_ready);
  assign is_hello = (q_desc.kind == mprf_pkg::KIND_HELLO);
  assign is_fwd   = (q_desc.kind == mprf_pkg::KIND_FORWARD);

  // neighbour table: membership check, then first empty slot
  always_comb begin
    present    = 1'b0;
    found      = 1'b0;
    empty_slot = '0;
    nbr_nxt    = nbr_r;
    for (int i = 0; i < mprf_pkg::NEIGHBOUR_SLOTS; i++) begin
      if (nbr_r[i] == q_desc.src) begin
        present = 1'b1;
      end
    end
    for (int i = 0; i < mprf_pkg::NEIGHBOUR_SLOTS; i++) begin
      if (!found && nbr_r[i] == 8'd0) begin
        found      = 1'b1;
        empty_slot = 3'(i);
        if (is_hello && !present) begin
          nbr_nxt[i] = q_desc.src;
        end
      end
    end
    if (!is_hello) begin
      outcome = mprf_pkg::NBR_NONE;
      slot    = '0;
    end else if (present) begin
      outcome = mprf_pkg::NBR_PRESENT;
      slot    = '0;
    end else if (found) begin
      outcome = mprf_pkg::NBR_STORED;
      slot    = empty_slot;
    end else begin
      outcome = mprf_pkg::NBR_FULL;
      slot    = '0;
    end
  end

  // recent checksum store, index 0 newest
  always_comb begin
    seen   = 1'b0;
    rc_nxt = rc_r;
    for (int i = 0; i < mprf_pkg::RECENT_DEPTH; i++) begin
      if (rc_r[i] == q_desc.rx_crc) begin
        seen = 1'b1;
      end
    end
    if (is_fwd && !seen) begin
      for (int i = 1; i < mprf_pkg::RECENT_DEPTH; i++) begin
        rc_nxt[i] = rc_r[i-1];
      end
      rc_nxt[0] = q_desc.rx_crc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbr_r       <= '0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        nbr_r       <= nbr_nxt;
        rc_r        <= rc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r    <= q_desc.kind;
      match_r   <= q_desc.crc_match;
      src_r     <= q_desc.src;
      dst_r     <= q_desc.dst;
      reply_r   <= is_hello;
      outcome_r <= outcome;
      slot_r    <= slot;
      seen_r    <= is_fwd && seen;
      fwd_r     <= is_fwd && !seen;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_packet_kind       = kind_r;
  assign out_crc_match         = match_r;
  assign out_source_address    = src_r;
  assign out_dest_address      = dst_r;
  assign out_reply_hello       = reply_r;
  assign out_neighbour_outcome = outcome_r;
  assign out_neighbour_slot    = slot_r;
  assign out_seen_before       = seen_r;
  assign out_forward_now       = fwd_r;

endmodule

// File: test/mesh_filter_checker.sv
`timescale 1ns / 100ps

package mprf_tb_pkg;

  localparam logic [15:0] XMODEM_POLY = 16'h1021;

  localparam mprf_pkg::cfg_t REG_DEFAULTS = '{
    own_address:     8'd65,
    hello_code:      8'd72,
    nlist_code:      8'd78,
    message_code:    8'd77,
    single_hop_code: 8'd83
  };

  // bit-serial XModem update, MSB of the byte first
  function automatic logic [15:0] crc_xmodem_next(input logic [15:0] acc,
                                                  input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0} ^ (fb ? XMODEM_POLY : 16'h0000);
    end
    return r;
  endfunction

endpackage

module mesh_filter_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_packet_kind,
  input  logic       out_crc_match,
  input  logic [7:0] out_source_address,
  input  logic [7:0] out_dest_address,
  input  logic       out_reply_hello,
  input  logic [1:0] out_neighbour_outcome,
  input  logic [2:0] out_neighbour_slot,
  input  logic       out_seen_before,
  input  logic       out_forward_now,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  import mprf_pkg::*;
  import mprf_tb_pkg::*;

  typedef struct packed {
    kind_t        kind;
    logic         crc_match;
    logic [7:0]   src;
    logic [7:0]   dst;
    logic         reply;
    nbr_outcome_t outcome;
    logic [2:0]   slot;
    logic         seen;
    logic         fwd;
  } verdict_t;

  cfg_t        regs;
  logic [15:0] pkt_crc;
  logic [7:0]  pkt_tail [2];
  logic [7:0]  pkt_hdr [4];
  logic [7:0]  pkt_count;
  logic [7:0]  nbr_table [NEIGHBOUR_SLOTS];
  logic [15:0] recent [RECENT_DEPTH];
  verdict_t    expected_verdicts [$];
  int          bad_results = 0;
  int          results_seen = 0;

  function automatic void clear_packet();
    pkt_crc   = '0;
    pkt_count = '0;
    foreach (pkt_tail[i]) pkt_tail[i] = '0;
    foreach (pkt_hdr[i]) pkt_hdr[i] = '0;
  endfunction

  function automatic void reset_model();
    regs = REG_DEFAULTS;
    clear_packet();
    foreach (nbr_table[i]) nbr_table[i] = '0;
    foreach (recent[i]) recent[i] = '0;
    expected_verdicts.delete();
  endfunction

  function automatic void set_register(input logic [2:0] idx, input logic [7:0] val);
    case (idx)
      CFG_OWN_ADDRESS:  regs.own_address = val;
      CFG_HELLO_CODE:   regs.hello_code = val;
      CFG_NLIST_CODE:   regs.nlist_code = val;
      CFG_MESSAGE_CODE: regs.message_code = val;
      CFG_SINGLE_HOP:   regs.single_hop_code = val;
      default: ;
    endcase
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    verdict_t    v;
    logic [15:0] rx;
    logic        hit;
    int          free_slot;
    if (pkt_count >= CRC_SKIP) pkt_crc = crc_xmodem_next(pkt_crc, pkt_tail[0]);
    pkt_tail[0] = pkt_tail[1];
    pkt_tail[1] = b;
    if (pkt_count < HDR_BYTES) pkt_hdr[pkt_count[1:0]] = b;
    if (pkt_count < CNT_MAX) pkt_count++;
    if (!last) return;

    v     = '0;
    rx    = {pkt_tail[0], pkt_tail[1]};
    v.src = pkt_hdr[2];
    v.dst = pkt_hdr[3];
    if (pkt_count < RUNT_LIMIT) begin
      v.kind = KIND_RUNT;
    end else begin
      v.crc_match = (rx == pkt_crc);
      if (pkt_hdr[0] == regs.hello_code) begin
        v.kind  = KIND_HELLO;
        v.reply = 1'b1;
        hit = 1'b0;
        foreach (nbr_table[i]) if (nbr_table[i] == pkt_hdr[2]) hit = 1'b1;
        if (hit) begin
          v.outcome = NBR_PRESENT;
        end else begin
          v.outcome = NBR_FULL;
          free_slot = -1;
          foreach (nbr_table[i]) if (free_slot < 0 && nbr_table[i] == '0) free_slot = i;
          if (free_slot >= 0) begin
            nbr_table[free_slot] = pkt_hdr[2];
            v.outcome = NBR_STORED;
            v.slot    = free_slot[2:0];
          end
        end
      end else if (pkt_hdr[0] == regs.nlist_code) begin
        v.kind = KIND_NLIST;
      end else if (pkt_hdr[0] == regs.message_code) begin
        if (pkt_hdr[3] == regs.own_address) begin
          v.kind = KIND_FOR_ME;
        end else if (pkt_hdr[1] != regs.single_hop_code) begin
          v.kind = KIND_FORWARD;
          hit = 1'b0;
          foreach (recent[i]) if (recent[i] == rx) hit = 1'b1;
          v.seen = hit;
          if (!hit) begin
            for (int i = RECENT_DEPTH - 1; i > 0; i--) recent[i] = recent[i - 1];
            recent[0] = rx;
            v.fwd = 1'b1;
          end
        end else begin
          v.kind = KIND_DROP;
        end
      end
    end
    expected_verdicts.push_back(v);
    clear_packet();
  endfunction

  function automatic string verdict_str(input verdict_t v);
    return $sformatf("kind %0d crc %0b src %02h dst %02h hello %0b nbr %0d slot %0d seen %0b fwd %0b",
                     v.kind, v.crc_match, v.src, v.dst, v.reply, v.outcome, v.slot,
                     v.seen, v.fwd);
  endfunction

  function automatic void check_result();
    verdict_t got;
    verdict_t want;
    got.kind      = kind_t'(out_packet_kind);
    got.crc_match = out_crc_match;
    got.src       = out_source_address;
    got.dst       = out_dest_address;
    got.reply     = out_reply_hello;
    got.outcome   = nbr_outcome_t'(out_neighbour_outcome);
    got.slot      = out_neighbour_slot;
    got.seen      = out_seen_before;
    got.fwd       = out_forward_now;
    results_seen++;
    if (expected_verdicts.size() == 0) begin
      bad_results++;
      if (bad_results <= 10) $display("result %0d not expected: %s", results_seen,
                                      verdict_str(got));
    end else begin
      want = expected_verdicts.pop_front();
      if (got !== want) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("result %0d mismatch", results_seen);
          $display("  expected %s", verdict_str(want));
          $display("  actual   %s", verdict_str(got));
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) set_register(cfg_index, cfg_data);
      if (in_valid === 1'b1 && in_ready === 1'b1) absorb_byte(in_data_byte, in_last_byte);
      if (out_valid === 1'b1 && out_ready === 1'b1) check_result();
    end
    fail_count <= bad_results;
    pending    <= expected_verdicts.size();
    checked    <= results_seen;
  end

endmodule

// File: test/tb_mesh_packet_receive_filter_core.sv
`timescale 1ns / 100ps

module tb_mesh_packet_receive_filter_core;

  import mprf_pkg::*;
  import mprf_tb_pkg::*;

  typedef logic [7:0] byte_q_t [$];
  typedef enum {CRC_GOOD, CRC_BAD, CRC_ZERO} crc_style_t;

  localparam int GAP_MAX       = 14;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS    = 5_000_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_data_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  logic       in_ready;
  logic       out_valid;
  logic [2:0] out_packet_kind;
  logic       out_crc_match;
  logic [7:0] out_source_address;
  logic [7:0] out_dest_address;
  logic       out_reply_hello;
  logic [1:0] out_neighbour_outcome;
  logic [2:0] out_neighbour_slot;
  logic       out_seen_before;
  logic       out_forward_now;
  logic       cfg_ready;

  int      fails;
  int      pending;
  int      checked;
  cfg_t    cur;
  bit      no_idle = 1'b0;
  bit      hold_req = 1'b0;
  int      bytes_sent = 0;
  int      packets_sent = 0;
  int      settings_used = 1;
  byte_q_t last_fwd;
  byte_q_t prev_fwd;

  mesh_packet_receive_filter_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .in_last_byte          (in_last_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_packet_kind       (out_packet_kind),
    .out_crc_match         (out_crc_match),
    .out_source_address    (out_source_address),
    .out_dest_address      (out_dest_address),
    .out_reply_hello       (out_reply_hello),
    .out_neighbour_outcome (out_neighbour_outcome),
    .out_neighbour_slot    (out_neighbour_slot),
    .out_seen_before       (out_seen_before),
    .out_forward_now       (out_forward_now),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  mesh_filter_checker u_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .in_last_byte          (in_last_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_packet_kind       (out_packet_kind),
    .out_crc_match         (out_crc_match),
    .out_source_address    (out_source_address),
    .out_dest_address      (out_dest_address),
    .out_reply_hello       (out_reply_hello),
    .out_neighbour_outcome (out_neighbour_outcome),
    .out_neighbour_slot    (out_neighbour_slot),
    .out_seen_before       (out_seen_before),
    .out_forward_now       (out_forward_now),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .fail_count            (fails),
    .pending               (pending),
    .checked               (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("mesh_packet_receive_filter_core regression: fail");
    $finish;
  end

  // result side: per-item stall, plus one long hold on request
  initial begin
    int gap;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_packet(input byte_q_t p);
    for (int i = 0; i < p.size(); i++) send_byte(p[i], i == p.size() - 1);
    packets_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic apply_settings(input cfg_t c);
    drain();
    cfg_put(CFG_OWN_ADDRESS, c.own_address);
    cfg_put(CFG_HELLO_CODE, c.hello_code);
    cfg_put(CFG_NLIST_CODE, c.nlist_code);
    cfg_put(CFG_MESSAGE_CODE, c.message_code);
    cfg_put(CFG_SINGLE_HOP, c.single_hop_code);
    // unused index, must be ignored
    cfg_put(CFG_SINGLE_HOP + 3'd1 + 3'($urandom_range(0, 2)), 8'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur = c;
    settings_used++;
  endtask

  function automatic byte_q_t make_packet(input logic [7:0] c1, input logic [7:0] c2,
                                          input logic [7:0] src, input logic [7:0] dst,
                                          input int body_len, input crc_style_t style);
    byte_q_t     p;
    logic [15:0] c;
    p.push_back(c1);
    p.push_back(c2);
    p.push_back(src);
    p.push_back(dst);
    repeat (body_len) p.push_back(8'($urandom));
    c = '0;
    foreach (p[i]) c = crc_xmodem_next(c, p[i]);
    case (style)
      CRC_GOOD: begin
        p.push_back(c[15:8]);
        p.push_back(c[7:0]);
      end
      CRC_ZERO: begin
        p.push_back(8'h00);
        p.push_back(8'h00);
      end
      default: begin
        p.push_back(8'($urandom));
        p.push_back(8'($urandom));
      end
    endcase
    return p;
  endfunction

  // small address pool so the table fills and repeats show up
  function automatic logic [7:0] hello_source();
    return ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 12));
  endfunction

  function automatic byte_q_t random_packet();
    byte_q_t    p;
    int         pick;
    int         n;
    logic [7:0] c2;
    logic [7:0] dst;
    crc_style_t style;
    pick  = $urandom_range(0, 99);
    n     = $urandom_range(0, 6);
    style = ($urandom_range(0, 3) == 0) ? CRC_BAD : CRC_GOOD;
    if ($urandom_range(0, 19) == 0) style = CRC_ZERO;
    if (pick < 25) begin
      p = make_packet(cur.hello_code, 8'($urandom), hello_source(), 8'($urandom), n, style);
    end else if (pick < 35) begin
      p = make_packet(cur.nlist_code, 8'($urandom), 8'($urandom), 8'($urandom), n, style);
    end else if (pick < 75) begin
      if (pick < 48 && last_fwd.size() > 0) begin
        if ($urandom_range(0, 2) == 0 && prev_fwd.size() > 0) begin
          p = prev_fwd;
        end else begin
          p = last_fwd;
        end
      end else begin
        c2  = 8'($urandom);
        dst = 8'($urandom);
        case ($urandom_range(0, 3))
          0: dst = cur.own_address;
          1: c2 = cur.single_hop_code;
          default: ;
        endcase
        p = make_packet(cur.message_code, c2, 8'($urandom), dst, n, style);
        prev_fwd = last_fwd;
        last_fwd = p;
      end
    end else if (pick < 85) begin
      p = make_packet(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), n, style);
    end else if (pick < 95) begin
      // runt, often carrying the hello code
      p.push_back($urandom_range(0, 1) ? cur.hello_code : 8'($urandom));
      repeat ($urandom_range(0, 4)) p.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 12)) p.push_back(8'($urandom));
    end
    return p;
  endfunction

  task automatic run_phase(input int budget);
    int      start;
    byte_q_t p;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      p = random_packet();
      no_idle = ($urandom_range(0, 6) == 0);
      send_packet(p);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    byte_q_t p;
    cfg_t    c;
    cur = REG_DEFAULTS;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte runt, then a runt carrying the hello code
    p.push_back(8'hFF);
    send_packet(p);
    p = make_packet(cur.hello_code, 8'h00, 8'hAA, 8'h55, 0, CRC_GOOD);
    void'(p.pop_back());
    send_packet(p);
    // shortest hello, forward with zero checksum, forward with a new checksum
    send_packet(make_packet(cur.hello_code, 8'h00, 8'h21, 8'hFF, 0, CRC_GOOD));
    send_packet(make_packet(cur.message_code, 8'h00, 8'h30, 8'h00, 0, CRC_ZERO));
    send_packet(make_packet(cur.message_code, 8'hFF, 8'h30, 8'h99, 0, CRC_GOOD));

    run_phase(35);

    // back-pressure: receiver holds while short packets keep coming
    drain();
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (8) begin
      p.delete();
      p.push_back(8'($urandom));
      send_packet(p);
    end
    // packet long enough to saturate the byte count
    send_packet(make_packet(cur.message_code, 8'h01, 8'h5A, ~cur.own_address,
                            252 + $urandom_range(0, 6), CRC_GOOD));
    no_idle = 1'b0;

    apply_settings('0);
    run_phase(25);
    apply_settings('1);
    run_phase(25);
    repeat (2) begin
      c.own_address     = 8'($urandom);
      c.hello_code      = 8'($urandom);
      c.nlist_code      = 8'($urandom);
      c.message_code    = 8'($urandom);
      c.single_hop_code = 8'($urandom);
      apply_settings(c);
      run_phase(25);
    end

    drain();
    $display("sent %0d bytes in %0d packets under %0d register settings", bytes_sent,
             packets_sent, settings_used);
    $display("%0d result items compared, %0d failures", checked, fails);
    if (fails == 0) begin
      $display("mesh_packet_receive_filter_core regression: pass");
    end else begin
      $display("mesh_packet_receive_filter_core regression: fail");
    end
    $finish;
  end

endmodule
